// File: sv/bhc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhc_pkg;

	// Sizes of the codec
	localparam int SYM_CNT      = 256;
	localparam int NODE_CNT     = 511;
	localparam int COUNT_W      = 32;
	localparam int MAX_CODE_LEN = 255;

	localparam int SYM_W   = $clog2(SYM_CNT);
	localparam int NODE_W  = $clog2(NODE_CNT);
	localparam int CHILD_W = NODE_W + 1;
	// merged weights hold the sum of all counts
	localparam int WGT_W   = COUNT_W + SYM_W;
	localparam int CHUNK_W = 64;
	localparam int CLEN_W  = $clog2(CHUNK_W + 1);
	localparam int LEN_W   = $clog2(MAX_CODE_LEN + 1);
	localparam int PATH_W  = (MAX_CODE_LEN < CHUNK_W) ? CHUNK_W : MAX_CODE_LEN;

	// Stream widths
	localparam int MODE_W     = 3;
	localparam int KIND_W     = 2;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 104;

	localparam logic [NODE_W-1:0]  ROOT      = NODE_W'(NODE_CNT - 1);
	localparam logic [CHILD_W-1:0] NO_NODE   = '1;
	localparam logic [WGT_W-1:0]   COUNT_MAX = WGT_W'({COUNT_W{1'b1}});

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR  = 3'd0,
		MODE_COUNT  = 3'd1,
		MODE_BUILD  = 3'd2,
		MODE_ENCODE = 3'd3,
		MODE_DECODE = 3'd4,
		MODE_READ   = 3'd5,
		MODE_WRITE  = 3'd6
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_CHUNK = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_NODE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_TCLR,
		ST_IDLE,
		ST_CNT_UPD,
		ST_SCAN,
		ST_TOPA,
		ST_TOPB,
		ST_MRG1,
		ST_MRG2,
		ST_ENC_WALK,
		ST_ENC_OUT,
		ST_DEC_CHK0,
		ST_DEC_CHK1,
		ST_NODE_OUT,
		ST_WR_NODE,
		ST_WR_PAR1
	} state_t;

	// out-of-range children are stored as a leaf mark
	function automatic logic [CHILD_W-1:0] child_sane(input logic [CHILD_W-1:0] v);
		if (v == NO_NODE || (!v[CHILD_W-1] && v < CHILD_W'(NODE_CNT)))
			return v;
		else
			return NO_NODE;
	endfunction

endpackage

`default_nettype wire

// File: sv/byte_huffman_codec_top.sv
// Encode walks the parent memory up from the leaf, then emits the code in 64-bit chunks.
// Build: a sweep over all 511 tree nodes, then per merge two scans of the 256-entry
// histogram and the TOPA, TOPB, MRG1 and MRG2 steps.
// One item is in work at a time; a result waits in the output register.
// Reset (arst_n low, asynchronous) clears control; a sweep over all tree nodes then
// runs before the first transfer is accepted.
`timescale 1ns / 1ps
`default_nettype none

module byte_huffman_codec_top
	import bhc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// symbol[7:0], bit_in[8], node_index[17:9], child_zero[27:18], child_one[37:28]
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// mode[2:0]
	input  wire logic [MODE_W-1:0]     s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// code_chunk[63:0], chunk_length[70:64], decoded_byte[78:71],
	// node_child_zero[88:79], node_child_one[98:89]
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// result_kind[1:0]
	output logic [KIND_W-1:0]          m_tuser,
	// last_chunk
	output logic                       m_tlast
);

	// Memories
	logic [WGT_W-1:0]       cnt_mem  [SYM_CNT];
	logic [2*CHILD_W-1:0]   node_mem [NODE_CNT];
	logic [CHILD_W:0]       par_mem  [NODE_CNT];
	logic [NODE_W-1:0]      top_mem  [SYM_CNT];

	logic [WGT_W-1:0]     cnt_rd_q;
	logic [2*CHILD_W-1:0] node_rd_q;
	logic [CHILD_W:0]     par_rd_q;
	logic [NODE_W-1:0]    top_rd_q;

	logic                 cnt_we, cnt_re, node_we, node_re, par_we, par_re, top_we, top_re;
	logic [SYM_W-1:0]     cnt_wa, cnt_ra, top_wa, top_ra;
	logic [WGT_W-1:0]     cnt_wd;
	logic [NODE_W-1:0]    node_wa, node_ra, par_wa, par_ra, top_wd;
	logic [2*CHILD_W-1:0] node_wd;
	logic [CHILD_W:0]     par_wd;

	// Control state
	state_t               state_q, state_d;
	logic [SYM_CNT-1:0]   cnt_vld_q, spent_q;
	logic [NODE_W-1:0]    clr_q, i_q, pos_q;
	logic                 build_q;
	logic [SYM_W:0]       scan_q;
	logic                 scan_v_s1, found_q, pass_b_q;
	logic [LEN_W-1:0]     len_q, rem_q;
	logic                 out_valid_q;

	// Payload registers
	logic [SYM_W-1:0]     sym_q, scan_idx_s1, best_idx_q, a_idx_q;
	logic                 bit_q, scan_live_s1, scan_vld_s1;
	logic [NODE_W-1:0]    idx_q, ta_q, tb_q, nxt_q;
	logic [CHILD_W-1:0]   c0_q, c1_q;
	logic [WGT_W-1:0]     best_w_q, a_w_q;
	logic [PATH_W-1:0]    path_q;
	kind_t                out_kind_q;
	logic [CHUNK_W-1:0]   out_chunk_q;
	logic [CLEN_W-1:0]    out_clen_q;
	logic                 out_last_q;
	logic [7:0]           out_byte_q;
	logic [CHILD_W-1:0]   out_nc0_q, out_nc1_q;

	// Input fields
	mode_t                in_mode;
	logic [SYM_W-1:0]     in_sym;
	logic                 in_bit;
	logic [NODE_W-1:0]    in_idx;
	logic [CHILD_W-1:0]   in_c0, in_c1;
	logic                 accept, out_free;

	assign in_mode  = mode_t'(s_tuser);
	assign in_sym   = s_tdata[7:0];
	assign in_bit   = s_tdata[8];
	assign in_idx   = s_tdata[17:9];
	assign in_c0    = s_tdata[27:18];
	assign in_c1    = s_tdata[37:28];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Count update
	logic [WGT_W-1:0] cnt_eff;
	logic             cnt_inc;
	assign cnt_eff = cnt_vld_q[sym_q] ? cnt_rd_q : '0;
	assign cnt_inc = !spent_q[sym_q] && (cnt_eff < COUNT_MAX);

	// Histogram scan: issue one read a cycle, compare the read data in the cycle after
	logic             scan_issue, scan_take, scan_done;
	logic [WGT_W-1:0] scan_w;
	assign scan_issue = (state_q == ST_SCAN) && (scan_q < (SYM_W+1)'(SYM_CNT));
	assign scan_w     = scan_vld_s1 ? cnt_rd_q : '0;
	assign scan_take  = scan_v_s1 && scan_live_s1 && (!found_q || scan_w < best_w_q);
	assign scan_done  = (state_q == ST_SCAN) && (scan_q == (SYM_W+1)'(SYM_CNT)) && !scan_v_s1;

	// Upward walk for encode
	logic [CHILD_W-1:0] e_par;
	logic               e_bit, e_step, e_last;
	logic [CLEN_W-1:0]  e_clen;
	logic [CHUNK_W-1:0] e_chunk;
	assign e_par   = par_rd_q[CHILD_W:1];
	assign e_bit   = par_rd_q[0];
	assign e_step  = !e_par[CHILD_W-1] && (len_q < LEN_W'(MAX_CODE_LEN));
	assign e_last  = (rem_q <= LEN_W'(CHUNK_W));
	assign e_clen  = e_last ? rem_q[CLEN_W-1:0] : CLEN_W'(CHUNK_W);
	assign e_chunk = path_q[PATH_W-1 -: CHUNK_W] >> (CLEN_W'(CHUNK_W) - e_clen);

	// Decode step
	logic [CHILD_W-1:0] d_c0, d_c1, d_next;
	assign d_c0   = node_rd_q[CHILD_W-1:0];
	assign d_c1   = node_rd_q[2*CHILD_W-1:CHILD_W];
	assign d_next = bit_q ? d_c1 : d_c0;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_TCLR: begin
				if (clr_q == ROOT) state_d = build_q ? ST_SCAN : ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_mode)
						MODE_CLEAR:  state_d = ST_IDLE;
						MODE_COUNT:  state_d = ST_CNT_UPD;
						MODE_BUILD:  state_d = ST_TCLR;
						MODE_ENCODE: state_d = ST_ENC_WALK;
						MODE_DECODE: state_d = ST_DEC_CHK0;
						MODE_READ:   state_d = ST_NODE_OUT;
						MODE_WRITE:  state_d = (in_idx < NODE_W'(NODE_CNT)) ? ST_WR_NODE : ST_IDLE;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_CNT_UPD: state_d = ST_IDLE;
			ST_SCAN: begin
				if (scan_done) begin
					if (!found_q)     state_d = ST_IDLE;
					else if (pass_b_q) state_d = ST_TOPA;
				end
			end
			ST_TOPA: state_d = ST_TOPB;
			ST_TOPB: state_d = ST_MRG1;
			ST_MRG1: state_d = ST_MRG2;
			ST_MRG2: state_d = (i_q == ROOT) ? ST_IDLE : ST_SCAN;
			ST_ENC_WALK: begin
				if (!e_step) state_d = ST_ENC_OUT;
			end
			ST_ENC_OUT: begin
				if (out_free && e_last) state_d = ST_IDLE;
			end
			ST_DEC_CHK0: begin
				if (d_c0[CHILD_W-1]) begin
					if (out_free) state_d = ST_IDLE;
				end else if (d_next[CHILD_W-1]) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_DEC_CHK1;
				end
			end
			ST_DEC_CHK1: begin
				if (!d_c0[CHILD_W-1] || out_free) state_d = ST_IDLE;
			end
			ST_NODE_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_WR_NODE: state_d = ST_WR_PAR1;
			ST_WR_PAR1: state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Memory ports and result load
	logic               out_load, load_last;
	kind_t              load_kind;
	logic [CHUNK_W-1:0] load_chunk;
	logic [CLEN_W-1:0]  load_clen;
	logic [7:0]         load_byte;
	logic [CHILD_W-1:0] load_nc0, load_nc1;

	always_comb begin
		cnt_we = 1'b0; cnt_wa = '0; cnt_wd = '0; cnt_re = 1'b0; cnt_ra = '0;
		node_we = 1'b0; node_wa = '0; node_wd = '0; node_re = 1'b0; node_ra = '0;
		par_we = 1'b0; par_wa = '0; par_wd = '0; par_re = 1'b0; par_ra = '0;
		top_we = 1'b0; top_wa = '0; top_wd = '0; top_re = 1'b0; top_ra = '0;
		out_load = 1'b0; load_kind = KIND_CHUNK; load_chunk = '0; load_clen = '0;
		load_last = 1'b0; load_byte = '0; load_nc0 = '0; load_nc1 = '0;
		unique case (state_q)
			ST_TCLR: begin
				node_we = 1'b1; node_wa = clr_q; node_wd = {NO_NODE, NO_NODE};
				par_we  = 1'b1; par_wa  = clr_q; par_wd  = {NO_NODE, 1'b1};
				if (clr_q < NODE_W'(SYM_CNT)) begin
					top_we = 1'b1; top_wa = clr_q[SYM_W-1:0]; top_wd = clr_q;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					unique case (in_mode)
						MODE_COUNT: begin
							cnt_re = 1'b1; cnt_ra = in_sym;
						end
						MODE_ENCODE: begin
							par_re = 1'b1; par_ra = NODE_W'(in_sym);
						end
						MODE_DECODE: begin
							node_re = 1'b1; node_ra = pos_q;
						end
						MODE_READ: begin
							node_re = (in_idx < NODE_W'(NODE_CNT)); node_ra = in_idx;
						end
						default: ;
					endcase
				end
			end
			ST_CNT_UPD: begin
				cnt_we = cnt_inc; cnt_wa = sym_q; cnt_wd = cnt_eff + WGT_W'(1);
			end
			ST_SCAN: begin
				cnt_re = scan_issue; cnt_ra = scan_q[SYM_W-1:0];
			end
			ST_TOPA: begin
				top_re = 1'b1; top_ra = a_idx_q;
			end
			ST_TOPB: begin
				top_re = 1'b1; top_ra = best_idx_q;
			end
			ST_MRG1: begin
				par_we  = 1'b1; par_wa = ta_q; par_wd = {1'b0, i_q, 1'b0};
				node_we = 1'b1; node_wa = i_q; node_wd = {1'b0, top_rd_q, 1'b0, ta_q};
				cnt_we  = 1'b1; cnt_wa = best_idx_q; cnt_wd = a_w_q + best_w_q;
				top_we  = 1'b1; top_wa = best_idx_q; top_wd = i_q;
			end
			ST_MRG2: begin
				par_we = 1'b1; par_wa = tb_q; par_wd = {1'b0, i_q, 1'b1};
			end
			ST_ENC_WALK: begin
				par_re = e_step; par_ra = e_par[NODE_W-1:0];
			end
			ST_ENC_OUT: begin
				out_load = out_free; load_kind = KIND_CHUNK; load_chunk = e_chunk;
				load_clen = e_clen; load_last = e_last;
			end
			ST_DEC_CHK0: begin
				if (d_c0[CHILD_W-1]) begin
					out_load = out_free; load_kind = KIND_BYTE; load_byte = pos_q[7:0];
				end else if (!d_next[CHILD_W-1]) begin
					node_re = 1'b1; node_ra = d_next[NODE_W-1:0];
				end
			end
			ST_DEC_CHK1: begin
				if (d_c0[CHILD_W-1]) begin
					out_load = out_free; load_kind = KIND_BYTE; load_byte = nxt_q[7:0];
				end
			end
			ST_NODE_OUT: begin
				out_load  = out_free; load_kind = KIND_NODE;
				load_nc0  = (idx_q < NODE_W'(NODE_CNT)) ? d_c0 : NO_NODE;
				load_nc1  = (idx_q < NODE_W'(NODE_CNT)) ? d_c1 : NO_NODE;
			end
			ST_WR_NODE: begin
				node_we = 1'b1; node_wa = idx_q; node_wd = {c1_q, c0_q};
				par_we  = !c0_q[CHILD_W-1]; par_wa = c0_q[NODE_W-1:0];
				par_wd  = {1'b0, idx_q, 1'b0};
			end
			ST_WR_PAR1: begin
				par_we = !c1_q[CHILD_W-1]; par_wa = c1_q[NODE_W-1:0];
				par_wd = {1'b0, idx_q, 1'b1};
			end
			default: ;
		endcase
	end

	// Synchronous memories, one write and one read port each
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_wa] <= node_wd;
		if (node_re) node_rd_q <= node_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_wa] <= par_wd;
		if (par_re) par_rd_q <= par_mem[par_ra];
	end

	always_ff @(posedge clk) begin
		if (top_we) top_mem[top_wa] <= top_wd;
		if (top_re) top_rd_q <= top_mem[top_ra];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TCLR;
			cnt_vld_q   <= '0;
			spent_q     <= '0;
			clr_q       <= '0;
			build_q     <= 1'b0;
			i_q         <= '0;
			pos_q       <= ROOT;
			scan_q      <= '0;
			scan_v_s1   <= 1'b0;
			found_q     <= 1'b0;
			pass_b_q    <= 1'b0;
			len_q       <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_TCLR: begin
					clr_q <= clr_q + NODE_W'(1);
					if (clr_q == ROOT) begin
						build_q  <= 1'b0;
						i_q      <= NODE_W'(SYM_CNT);
						scan_q   <= '0;
						pass_b_q <= 1'b0;
						found_q  <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (in_mode)
							MODE_CLEAR: begin
								cnt_vld_q <= '0;
								spent_q   <= '0;
							end
							MODE_BUILD: begin
								clr_q   <= '0;
								build_q <= 1'b1;
								pos_q   <= ROOT;
							end
							MODE_ENCODE: len_q <= '0;
							default: ;
						endcase
					end
				end
				ST_CNT_UPD: begin
					if (cnt_inc) cnt_vld_q[sym_q] <= 1'b1;
				end
				ST_SCAN: begin
					if (scan_issue) scan_q <= scan_q + (SYM_W+1)'(1);
					scan_v_s1 <= scan_issue;
					if (scan_take) found_q <= 1'b1;
					if (scan_done && found_q && !pass_b_q) begin
						pass_b_q <= 1'b1;
						scan_q   <= '0;
						found_q  <= 1'b0;
					end
				end
				ST_MRG1: begin
					cnt_vld_q[best_idx_q] <= 1'b1;
					spent_q[a_idx_q]      <= 1'b1;
				end
				ST_MRG2: begin
					if (i_q != ROOT) begin
						i_q      <= i_q + NODE_W'(1);
						scan_q   <= '0;
						pass_b_q <= 1'b0;
						found_q  <= 1'b0;
					end
				end
				ST_ENC_WALK: begin
					if (e_step) len_q <= len_q + LEN_W'(1);
					else        rem_q <= len_q;
				end
				ST_ENC_OUT: begin
					if (out_free) rem_q <= rem_q - LEN_W'(e_clen);
				end
				ST_DEC_CHK0: begin
					if (d_c0[CHILD_W-1]) begin
						if (out_free) pos_q <= ROOT;
					end else if (d_next[CHILD_W-1]) begin
						pos_q <= ROOT;
					end
				end
				ST_DEC_CHK1: begin
					if (d_c0[CHILD_W-1]) begin
						if (out_free) pos_q <= ROOT;
					end else begin
						pos_q <= nxt_q;
					end
				end
				default: ;
			endcase
			// output register
			if (out_load)      out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= in_sym;
			bit_q <= in_bit;
			idx_q <= in_idx;
			c0_q  <= child_sane(in_c0);
			c1_q  <= child_sane(in_c1);
		end
		if (scan_issue) begin
			scan_idx_s1  <= scan_q[SYM_W-1:0];
			scan_vld_s1  <= cnt_vld_q[scan_q[SYM_W-1:0]];
			scan_live_s1 <= !spent_q[scan_q[SYM_W-1:0]]
				&& !(pass_b_q && scan_q[SYM_W-1:0] == a_idx_q);
		end
		if (scan_take) begin
			best_idx_q <= scan_idx_s1;
			best_w_q   <= scan_w;
		end
		if (scan_done && !pass_b_q) begin
			a_idx_q <= best_idx_q;
			a_w_q   <= best_w_q;
		end
		if (state_q == ST_TOPB) ta_q <= top_rd_q;
		if (state_q == ST_MRG1) tb_q <= top_rd_q;
		if (state_q == ST_DEC_CHK0) nxt_q <= d_next[NODE_W-1:0];
		// leaf bit enters first, so the root bit ends at the top
		if (state_q == ST_ENC_WALK && e_step) path_q <= {e_bit, path_q[PATH_W-1:1]};
		else if (state_q == ST_ENC_OUT && out_free) path_q <= path_q << CHUNK_W;
		if (out_load) begin
			out_kind_q  <= load_kind;
			out_chunk_q <= load_chunk;
			out_clen_q  <= load_clen;
			out_last_q  <= load_last;
			out_byte_q  <= load_byte;
			out_nc0_q   <= load_nc0;
			out_nc1_q   <= load_nc1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_nc1_q, out_nc0_q, out_byte_q, out_clen_q, out_chunk_q};

`ifndef ASSERT_OFF
	// the second merge child is never the first one
	a_merge_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRG1) |-> (best_idx_q != a_idx_q))
		else $error("merge children coincide");

	// a result is loaded only into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || m_tready))
		else $error("result overwrote a pending transfer");

	// a chunk never carries more than one word of code bits
	a_chunk_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_clen_q <= CLEN_W'(CHUNK_W)))
		else $error("chunk length too large");

	// each merge advances the node counter by one
	a_node_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRG2 && state_d == ST_SCAN) |=> (i_q == $past(i_q) + NODE_W'(1)))
		else $error("merge node counter skipped");

	// decode position stays inside the tree
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < NODE_W'(NODE_CNT))
		else $error("decode position out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb_byte_huffman_codec_top.sv
`timescale 1ns / 1ps

module tb_byte_huffman_codec_top;
	import bhc_pkg::*;

	localparam logic [2:0] MODE_SPARE = 3'd7;    // unused opcode, ignored by the block
	localparam logic [9:0] LEAF       = 10'h3FF; // -1 in a child field
	localparam int         CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] chunk;
		logic [6:0]  clen;
		logic        last;
		logic [7:0]  dbyte;
		logic [9:0]  nc0;
		logic [9:0]  nc1;
	} codec_res_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] sym;
		logic       bit_in;
		logic [8:0] idx;
		logic [9:0] c0;
		logic [9:0] c1;
		logic       fixed;
		codec_res_t res;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [MODE_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]     m_tuser;
	logic                  m_tlast;

	byte_huffman_codec_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// Predictor state
	longint unsigned hist[256];
	bit              spent[256];
	int              kid0[511], kid1[511], up[511];
	bit              up_bit[511];
	int              walk_pos;
	bit              code_path[255];
	codec_res_t      pending_codes[$];

	int errors = 0, n_in = 0, n_out = 0, cycles = 0;
	int tx_idle = 15, rx_idle = 83;

	initial forever #2 clk = ~clk;

	function automatic void tree_wipe();
		for (int i = 0; i < 511; i++) begin
			kid0[i] = -1; kid1[i] = -1; up[i] = -1; up_bit[i] = 1'b1;
		end
		walk_pos = 510;
	endfunction

	function automatic int lightest_slot();
		int best;
		best = -1;
		for (int i = 0; i < 256; i++)
			if (!spent[i] && (best < 0 || hist[i] < hist[best]))
				best = i;
		return best;
	endfunction

	function automatic int tree_top(int n);
		int steps;
		steps = 0;
		while (n < 511 && up[n] >= 0 && steps < 511) begin
			n = up[n];
			steps++;
		end
		return n;
	endfunction

	function automatic void push_code(kind_t k, logic [63:0] ch, logic [6:0] cl, logic la,
			logic [7:0] db, logic [9:0] z, logic [9:0] o);
		codec_res_t r;
		r = '{k, ch, cl, la, db, z, o};
		pending_codes.push_back(r);
	endfunction

	function automatic int child_sanitize(logic [9:0] v);
		if (v == LEAF)
			return -1;
		if (v[9] || v >= 10'd511)
			return -1;
		return int'(v);
	endfunction

	// Huffman merge loop: two lightest live slots, ties to the lowest index
	function automatic void huff_build();
		int a, b, ta, tb;
		longint unsigned w;
		tree_wipe();
		for (int i = 256; i < 511; i++) begin
			a = lightest_slot();
			if (a < 0)
				break;
			spent[a] = 1'b1;
			b = lightest_slot();
			if (b < 0) begin
				spent[a] = 1'b0;
				break;
			end
			w = hist[a];
			hist[a] = 0;
			hist[b] += w;
			ta = tree_top(a);
			tb = tree_top(b);
			up[ta] = i; up_bit[ta] = 1'b0;
			up[tb] = i; up_bit[tb] = 1'b1;
			kid0[i] = ta; kid1[i] = tb;
		end
	endfunction

	// Walk from the leaf to the root, then emit root-first in 64-bit chunks
	function automatic void huff_encode(int sym);
		int len, n;
		logic [63:0] ch;
		logic [6:0] cl;
		len = 0; n = sym; ch = '0; cl = '0;
		while (len < 255 && up[n] >= 0) begin
			code_path[len] = up_bit[n];
			len++;
			n = up[n];
		end
		if (len == 0) begin
			push_code(KIND_CHUNK, '0, '0, 1'b1, '0, '0, '0);
			return;
		end
		for (int k = len - 1; k >= 0; k--) begin
			ch = {ch[62:0], code_path[k]};
			cl++;
			if (cl == 7'd64 || k == 0) begin
				push_code(KIND_CHUNK, ch, cl, k == 0, '0, '0, '0);
				ch = '0;
				cl = '0;
			end
		end
	endfunction

	function automatic void huff_decode(logic b);
		int nxt;
		if (kid0[walk_pos] < 0) begin
			push_code(KIND_BYTE, '0, '0, 1'b0, walk_pos[7:0], '0, '0);
			walk_pos = 510;
			return;
		end
		nxt = b ? kid1[walk_pos] : kid0[walk_pos];
		if (nxt < 0) begin
			walk_pos = 510;
		end else if (kid0[nxt] < 0) begin
			push_code(KIND_BYTE, '0, '0, 1'b0, nxt[7:0], '0, '0);
			walk_pos = 510;
		end else begin
			walk_pos = nxt;
		end
	endfunction

	// Expected results of one accepted transfer
	function automatic void huff_step(logic [2:0] md, logic [7:0] sym, logic b, logic [8:0] idx,
			logic [9:0] z, logic [9:0] o);
		int cz, co;
		case (md)
			MODE_CLEAR: begin
				for (int i = 0; i < 256; i++) begin
					hist[i] = 0; spent[i] = 1'b0;
				end
			end
			MODE_COUNT: begin
				if (!spent[sym] && hist[sym] < 64'hFFFF_FFFF)
					hist[sym]++;
			end
			MODE_BUILD:  huff_build();
			MODE_ENCODE: huff_encode(int'(sym));
			MODE_DECODE: huff_decode(b);
			MODE_READ: begin
				if (idx < 9'd511)
					push_code(KIND_NODE, '0, '0, 1'b0, '0, 10'(kid0[idx]), 10'(kid1[idx]));
				else
					push_code(KIND_NODE, '0, '0, 1'b0, '0, LEAF, LEAF);
			end
			MODE_WRITE: begin
				cz = child_sanitize(z);
				co = child_sanitize(o);
				if (idx < 9'd511) begin
					kid0[idx] = cz;
					kid1[idx] = co;
					if (cz >= 0) begin
						up[cz] = int'(idx); up_bit[cz] = 1'b0;
					end
					if (co >= 0) begin
						up[co] = int'(idx); up_bit[co] = 1'b1;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// One input transfer; optional random gap before it
	task automatic send_item(logic [2:0] md, logic [7:0] sym, logic b, logic [8:0] idx,
			logic [9:0] z, logic [9:0] o, logic fixed, codec_res_t fixed_res);
		int depth;
		if ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {2'b00, o, z, idx, b, sym};
		do @(posedge clk); while (!s_tready);
		n_in++;
		depth = pending_codes.size();
		huff_step(md, sym, b, idx, z, o);
		if (fixed) begin
			while (pending_codes.size() > depth)
				void'(pending_codes.pop_back());
			pending_codes.push_back(fixed_res);
		end
	endtask

	task automatic send_rand(logic [2:0] md, logic [7:0] sym);
		send_item(md, sym, 1'($urandom), 9'($urandom), 10'($urandom), 10'($urandom), 1'b0, '0);
	endtask

	// Drain, then hold off for an item that yields nothing
	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending_codes.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// Well-formed run: clear, skewed histogram, build, then mixed traffic
	task automatic random_phase(int n_mixed);
		int r;
		send_rand(MODE_CLEAR, 8'($urandom));
		for (int i = 0; i < 25; i++)
			send_rand(MODE_COUNT, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(15)));
		send_rand(MODE_BUILD, 8'($urandom));
		for (int i = 0; i < n_mixed; i++) begin
			r = $urandom_range(99);
			if (r < 35)      send_rand(MODE_DECODE, 8'($urandom));
			else if (r < 60) send_rand(MODE_ENCODE, 8'($urandom));
			else if (r < 72) send_rand(MODE_READ, 8'($urandom));
			else if (r < 82) send_rand(MODE_COUNT, 8'($urandom));
			else if (r < 90) send_rand(MODE_WRITE, 8'($urandom));
			else if (r < 94) send_rand(MODE_CLEAR, 8'($urandom));
			else if (r < 97) send_rand(MODE_SPARE, 8'($urandom));
			else             send_rand(MODE_DECODE, 8'($urandom));
		end
	endtask

	// Receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	// Result checker
	always @(posedge clk) begin
		codec_res_t want;
		if (m_tvalid && m_tready) begin
			n_out++;
			if (pending_codes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result kind=%0d data=%h last=%b", $time, m_tuser,
					m_tdata, m_tlast);
			end else begin
				want = pending_codes.pop_front();
				if (m_tuser != want.kind || m_tdata[63:0] != want.chunk
						|| m_tdata[70:64] != want.clen || m_tlast != want.last
						|| m_tdata[78:71] != want.dbyte || m_tdata[88:79] != want.nc0
						|| m_tdata[98:89] != want.nc1) begin
					errors++;
					$display("%0t: mismatch exp kind=%0d chunk=%h len=%0d last=%b byte=%h c0=%h c1=%h",
						$time, want.kind, want.chunk, want.clen, want.last, want.dbyte,
						want.nc0, want.nc1);
					$display("%0t:          got kind=%0d chunk=%h len=%0d last=%b byte=%h c0=%h c1=%h",
						$time, m_tuser, m_tdata[63:0], m_tdata[70:64], m_tlast,
						m_tdata[78:71], m_tdata[88:79], m_tdata[98:89]);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_byte_huffman_codec_top NOT OK");
			$finish;
		end
	end

	stim_row_t dir_rows[29];

	initial begin
		dir_rows = '{
			// reset tree: first and last nodes read as leaves, and so does an out-of-range index
			'{MODE_READ,   8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b1,
				'{KIND_NODE, 64'd0, 7'd0, 1'b0, 8'd0, LEAF, LEAF}},
			'{MODE_READ,   8'd0,   1'b0, 9'd510, LEAF, LEAF, 1'b1,
				'{KIND_NODE, 64'd0, 7'd0, 1'b0, 8'd0, LEAF, LEAF}},
			'{MODE_READ,   8'hFF,  1'b1, 9'd511, LEAF, LEAF, 1'b1,
				'{KIND_NODE, 64'd0, 7'd0, 1'b0, 8'd0, LEAF, LEAF}},
			// leaf with no parent: empty final chunk
			'{MODE_ENCODE, 8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b1,
				'{KIND_CHUNK, 64'd0, 7'd0, 1'b1, 8'd0, 10'd0, 10'd0}},
			// decode while sitting on a leaf root emits its index
			'{MODE_DECODE, 8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b1,
				'{KIND_BYTE, 64'd0, 7'd0, 1'b0, 8'hFE, 10'd0, 10'd0}},
			'{MODE_SPARE,  8'hFF,  1'b1, 9'h1FF, LEAF, LEAF, 1'b0, '0},
			// write out of range is dropped
			'{MODE_WRITE,  8'd0,   1'b0, 9'd511, 10'd5, 10'd6, 1'b0, '0},
			// parent loop 300 <-> 301 makes leaf 7's path overlong
			'{MODE_WRITE,  8'd0,   1'b0, 9'd300, 10'd7, 10'd301, 1'b0, '0},
			'{MODE_WRITE,  8'd0,   1'b0, 9'd301, 10'd300, 10'h200, 1'b0, '0},
			'{MODE_READ,   8'd0,   1'b0, 9'd301, LEAF, LEAF, 1'b1,
				'{KIND_NODE, 64'd0, 7'd0, 1'b0, 8'd0, 10'd300, LEAF}},
			'{MODE_ENCODE, 8'd7,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			// root with a missing bit-1 child
			'{MODE_WRITE,  8'd0,   1'b0, 9'd510, 10'd3, 10'd600, 1'b0, '0},
			'{MODE_DECODE, 8'd0,   1'b1, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_DECODE, 8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b1,
				'{KIND_BYTE, 64'd0, 7'd0, 1'b0, 8'd3, 10'd0, 10'd0}},
			'{MODE_ENCODE, 8'd255, 1'b0, 9'd0,   LEAF, LEAF, 1'b1,
				'{KIND_CHUNK, 64'd0, 7'd0, 1'b1, 8'd0, 10'd0, 10'd0}},
			// histogram, clear, refill and build
			'{MODE_COUNT,  8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_COUNT,  8'd255, 1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_COUNT,  8'd255, 1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_CLEAR,  8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_COUNT,  8'd255, 1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_COUNT,  8'd255, 1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_COUNT,  8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_COUNT,  8'd128, 1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_BUILD,  8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_ENCODE, 8'd255, 1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_ENCODE, 8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_DECODE, 8'd0,   1'b1, 9'd0,   LEAF, LEAF, 1'b0, '0},
			'{MODE_DECODE, 8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0},
			// rebuild without clear: only one live slot, merging stops at once
			'{MODE_BUILD,  8'd0,   1'b0, 9'd0,   LEAF, LEAF, 1'b0, '0}
		};

		for (int i = 0; i < 256; i++) begin
			hist[i] = 0; spent[i] = 1'b0;
		end
		tree_wipe();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_item(dir_rows[i].mode, dir_rows[i].sym, dir_rows[i].bit_in, dir_rows[i].idx,
				dir_rows[i].c0, dir_rows[i].c1, dir_rows[i].fixed, dir_rows[i].res);
		random_phase(30);
		drain();

		tx_idle = 83; rx_idle = 15;
		random_phase(30);
		drain();

		tx_idle = 0; rx_idle = 0;
		random_phase(30);
		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d transfers over three back-pressure profiles, %0d results checked",
			n_in, n_out);
		$display("(count, build, encode incl. overlong paths, decode, node read/write, clear)");
		if (errors == 0 && pending_codes.size() == 0)
			$display("tb_byte_huffman_codec_top OK");
		else
			$display("tb_byte_huffman_codec_top NOT OK");
		$finish;
	end

endmodule
